FILE: sv/crc8fp_pkg.sv
// shared types, codes and the crc-8/maxim byte update for the frame parser
package crc8fp_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_FIRST  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEADER_SECOND = 1'd1;

  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAB;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hCD;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_CRC_ERR = 2'd1;
  localparam logic [1:0] ST_LEN_ERR = 2'd2;

  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  // which kind of result the output register loads
  typedef enum logic [1:0] {
    OSEL_DATA    = 2'd0,
    OSEL_EMPTY   = 2'd1,
    OSEL_CRC_ERR = 2'd2,
    OSEL_LEN_ERR = 2'd3
  } osel_t;

  // controller to datapath
  typedef struct packed {
    logic  load_type;
    logic  load_len;
    logic  load_data;
    logic  replay_start;
    logic  replay_read;
    logic  replay_step;
    logic  emit;
    osel_t osel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_over;
    logic len_zero;
    logic held_zero;
    logic data_done;
    logic crc_ok;
    logic replay_last;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/crc8_frame_parser_core.sv
// top level of the crc-8/maxim frame parser
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | rx_byte
//  out      | out_valid / out_stall| status, frame_type, payload_length,
//           |                      | byte_index, data_byte, has_data, last
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
//  one byte per cycle while hunting headers and collecting type, length and payload
//  a good frame replays its payload byte by byte; each byte takes a registered
//  read of the payload memory followed by the output register load
//  input is stalled during replay, and on length and crc bytes while the output
//  register holds an untaken transaction
//  rst is synchronous, active high; it restores the header values 0xab / 0xcd
//  and returns the parser to the first-header hunt; payload memory is not cleared
module crc8_frame_parser_core #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // received bytes
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [7:0]                     frame_type,
  output logic [7:0]                     payload_length,
  output logic [4:0]                     byte_index,
  output logic [7:0]                     data_byte,
  output logic                           has_data,
  output logic                           last,
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [crc8fp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  crc8fp_pkg::cmd_t cmd;
  crc8fp_pkg::sts_t sts;

  // header registers take a write every cycle
  assign cfg_ready = 1'b1;

  crc8fp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  crc8fp_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .rx_byte        (rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .frame_type     (frame_type),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .last           (last)
  );

endmodule

FILE: sv/crc8fp_ctrl.sv
// parse and replay controller for the frame parser
module crc8fp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  crc8fp_pkg::sts_t    sts,
  output crc8fp_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_HDR1 = 8'b0000_0001,
    S_HDR2 = 8'b0000_0010,
    S_TYPE = 8'b0000_0100,
    S_LEN  = 8'b0000_1000,
    S_DATA = 8'b0001_0000,
    S_CRC  = 8'b0010_0000,
    S_RD   = 8'b0100_0000,
    S_WR   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;

  always_comb begin
    unique case (state)
      S_RD, S_WR:   in_stall = 1'b1;
      S_LEN, S_CRC: in_stall = !sts.out_free;
      default:      in_stall = 1'b0;
    endcase
  end

  assign in_fire = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.osel   = crc8fp_pkg::OSEL_DATA;
    unique case (state)
      S_HDR1: begin
        if (in_fire) state_next = sts.hdr1_hit ? S_HDR2 : S_HDR1;
      end
      S_HDR2: begin
        if (in_fire) begin
          priority if (sts.hdr2_hit) state_next = S_TYPE;
          else if (sts.hdr1_hit)     state_next = S_HDR2;
          else                       state_next = S_HDR1;
        end
      end
      S_TYPE: begin
        if (in_fire) begin
          cmd.load_type = 1'b1;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        if (in_fire) begin
          if (sts.len_over) begin
            cmd.emit   = 1'b1;
            cmd.osel   = crc8fp_pkg::OSEL_LEN_ERR;
            state_next = S_HDR1;
          end else begin
            cmd.load_len = 1'b1;
            state_next   = sts.len_zero ? S_CRC : S_DATA;
          end
        end
      end
      S_DATA: begin
        if (in_fire) begin
          cmd.load_data = 1'b1;
          if (sts.data_done) state_next = S_CRC;
        end
      end
      S_CRC: begin
        if (in_fire) begin
          priority if (!sts.crc_ok) begin
            cmd.emit   = 1'b1;
            cmd.osel   = crc8fp_pkg::OSEL_CRC_ERR;
            state_next = S_HDR1;
          end else if (sts.held_zero) begin
            cmd.emit   = 1'b1;
            cmd.osel   = crc8fp_pkg::OSEL_EMPTY;
            state_next = S_HDR1;
          end else begin
            cmd.replay_start = 1'b1;
            state_next       = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.replay_read = 1'b1;
        state_next      = S_WR;
      end
      S_WR: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.osel        = crc8fp_pkg::OSEL_DATA;
          cmd.replay_step = 1'b1;
          state_next      = sts.replay_last ? S_HDR1 : S_RD;
        end
      end
      default: state_next = S_HDR1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_HDR1;
    else     state <= state_next;
  end

endmodule

FILE: sv/crc8fp_dp.sv
// datapath: header registers, frame fields, crc, payload memory, output register
module crc8fp_dp #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [crc8fp_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data,
  input  logic [7:0]                         rx_byte,
  input  crc8fp_pkg::cmd_t                   cmd,
  output crc8fp_pkg::sts_t                   sts,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         status,
  output logic [7:0]                         frame_type,
  output logic [7:0]                         payload_length,
  output logic [4:0]                         byte_index,
  output logic [7:0]                         data_byte,
  output logic                               has_data,
  output logic                               last
);

  localparam int unsigned CntW  = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AddrW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]      hdr_first;
  logic [7:0]      hdr_second;
  logic [7:0]      held_type;
  logic [CntW-1:0] held_len;
  logic [CntW-1:0] count;
  logic [CntW-1:0] rd_idx;
  logic [7:0]      crc;
  logic [7:0]      rd_data;
  logic [7:0]      mem [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_first  <= crc8fp_pkg::HEADER_FIRST_RST;
      hdr_second <= crc8fp_pkg::HEADER_SECOND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crc8fp_pkg::CFG_HEADER_FIRST:  hdr_first  <= cfg_data;
        crc8fp_pkg::CFG_HEADER_SECOND: hdr_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_type <= '0;
      held_len  <= '0;
      count     <= '0;
      crc       <= '0;
      rd_idx    <= '0;
    end else begin
      if (cmd.load_type) begin
        held_type <= rx_byte;
        crc       <= crc8fp_pkg::crc8_byte(8'h00, rx_byte);
        count     <= '0;
      end
      if (cmd.load_len) begin
        held_len <= rx_byte[CntW-1:0];
        crc      <= crc8fp_pkg::crc8_byte(crc, rx_byte);
        count    <= '0;
      end
      if (cmd.load_data) begin
        crc   <= crc8fp_pkg::crc8_byte(crc, rx_byte);
        count <= count + CntW'(1);
      end
      if (cmd.replay_start)     rd_idx <= '0;
      else if (cmd.replay_step) rd_idx <= rd_idx + CntW'(1);
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_data) mem[count[AddrW-1:0]] <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (cmd.replay_read) rd_data <= mem[rd_idx[AddrW-1:0]];
  end

  always_comb begin
    sts.hdr1_hit    = (rx_byte == hdr_first);
    sts.hdr2_hit    = (rx_byte == hdr_second);
    sts.len_over    = (rx_byte > 8'(MAX_PAYLOAD));
    sts.len_zero    = (rx_byte == 8'h00);
    sts.held_zero   = (held_len == '0);
    sts.data_done   = ((count + CntW'(1)) == held_len);
    sts.crc_ok      = (rx_byte == crc);
    sts.replay_last = ((rd_idx + CntW'(1)) == held_len);
    sts.out_free    = !out_valid || !out_stall;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)              out_valid <= 1'b0;
    else if (cmd.emit)    out_valid <= 1'b1;
    else if (!out_stall)  out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame_type <= held_type;
      unique case (cmd.osel)
        crc8fp_pkg::OSEL_DATA: begin
          status         <= crc8fp_pkg::ST_GOOD;
          payload_length <= 8'(held_len);
          byte_index     <= 5'(rd_idx);
          data_byte      <= rd_data;
          has_data       <= 1'b1;
          last           <= sts.replay_last;
        end
        crc8fp_pkg::OSEL_EMPTY: begin
          status         <= crc8fp_pkg::ST_GOOD;
          payload_length <= 8'h00;
          byte_index     <= '0;
          data_byte      <= '0;
          has_data       <= 1'b0;
          last           <= 1'b1;
        end
        crc8fp_pkg::OSEL_CRC_ERR: begin
          status         <= crc8fp_pkg::ST_CRC_ERR;
          payload_length <= 8'(held_len);
          byte_index     <= '0;
          data_byte      <= '0;
          has_data       <= 1'b0;
          last           <= 1'b1;
        end
        crc8fp_pkg::OSEL_LEN_ERR: begin
          status         <= crc8fp_pkg::ST_LEN_ERR;
          payload_length <= rx_byte;
          byte_index     <= '0;
          data_byte      <= '0;
          has_data       <= 1'b0;
          last           <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule
